/* src/dwhr_pkg.sv */
// Shared types and constants for the double-ended queue with half rotate.
package dwhr_pkg;

  // Default storage shape
  localparam int unsigned DepthDef     = 64;
  localparam int unsigned DataWidthDef = 32;

  // Fixed widths of the transaction fields
  localparam int unsigned OpW     = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // Operation codes carried by opcode_i
  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SWAP       = 3'd4,
    OP_DUMP       = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_POPPED = 2'd0,
    ST_DUMPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SWAP,
    FSM_DUMP
  } fsm_e;

  // Result waiting on the memory read data register
  typedef struct packed {
    logic    valid;
    logic    zero;
    status_e status;
    logic    last;
  } slot_t;

endpackage

/* src/deque_with_half_rotate.sv */
// Bounded double-ended queue in a ring buffer memory, with pop, dump and half rotate.
//
// Usage: transactions enter on in_valid_i / in_stall_o with opcode_i and push_value_i,
// results leave on out_valid_o / out_stall_i as out_value_o, status_o and last_o.
// A transaction is taken at a clock edge where valid is high and stall is low.
// Push and pop do not hold the input after acceptance; a pop or an error result passes to
// the output through the read data register (memory read or error status), then the output register.
// Successful pushes and swaps produce no result; a failed push or pop, or a dump of an
// empty queue, produces one result with an error status and last set.
// Swap copies floor(count/2) entries through the one read port and the one write port,
// one entry per cycle, and holds the input until the last copy has been written.
// Dump reads one entry per cycle while the output does not stall, and keeps the input
// stalled until the last read has been issued.
// The element memory is not cleared: reset only zeroes the front index, the element
// count and the control state, and every occupied entry has been written before use.
// When the receiver stalls, the output register and the read data register hold their
// results; further reads, and so further input, wait until a slot frees up.
module deque_with_half_rotate #(
  parameter int unsigned DEPTH      = dwhr_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = dwhr_pkg::DataWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dwhr_pkg::OpW-1:0]            opcode_i,
  input  logic signed [dwhr_pkg::ValueW-1:0]  push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dwhr_pkg::ValueW-1:0]  out_value_o,
  output logic [dwhr_pkg::StatusW-1:0]        status_o,
  output logic                                last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Modular add of an index and an offset no larger than DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(b);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // State registers
  dwhr_pkg::fsm_e  state_q, state_d;
  logic [AW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   rp_q, rp_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic            sw_pend_q, sw_pend_d;
  dwhr_pkg::slot_t slot_q, slot_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic signed [dwhr_pkg::ValueW-1:0] out_value_q;
  dwhr_pkg::status_e             out_status_q;
  logic                          out_last_q;

  // Memory ports
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic [DATA_WIDTH-1:0] rdata_q;

  logic                  out_free, move, slot_free, accept;
  logic signed [DATA_WIDTH-1:0] rdata_s;
  dwhr_pkg::op_e         op;

  assign op        = dwhr_pkg::op_e'(opcode_i);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign move      = slot_q.valid && out_free;
  assign slot_free = !slot_q.valid || move;
  assign in_stall_o = (state_q != dwhr_pkg::FSM_IDLE) || !slot_free;
  assign accept    = in_valid_i && !in_stall_o;
  assign rdata_s   = $signed(rdata_q);

  // Element memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  // Sequencer, pointer updates and memory accesses
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    cnt_d     = cnt_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    sw_pend_d = 1'b0;
    slot_d    = slot_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = wp_q;
    mem_ra    = rp_q;
    mem_wd    = rdata_q;

    if (move) begin
      slot_d.valid = 1'b0;
    end

    case (state_q)
      dwhr_pkg::FSM_IDLE: begin
        if (accept) begin
          case (op)
            dwhr_pkg::OP_PUSH_FRONT, dwhr_pkg::OP_PUSH_BACK: begin
              if (count_q == CW'(DEPTH)) begin
                slot_d = '{valid: 1'b1, zero: 1'b1, status: dwhr_pkg::ST_FULL, last: 1'b1};
              end else begin
                mem_we  = 1'b1;
                mem_wd  = DATA_WIDTH'(push_value_i);
                count_d = count_q + CW'(1);
                if (op == dwhr_pkg::OP_PUSH_FRONT) begin
                  front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
                  mem_wa  = front_d;
                end else begin
                  mem_wa  = wrap_add(front_q, count_q);
                end
              end
            end
            dwhr_pkg::OP_POP_FRONT, dwhr_pkg::OP_POP_BACK: begin
              if (count_q == '0) begin
                slot_d = '{valid: 1'b1, zero: 1'b1, status: dwhr_pkg::ST_EMPTY, last: 1'b1};
              end else begin
                mem_re  = 1'b1;
                count_d = count_q - CW'(1);
                slot_d  = '{valid: 1'b1, zero: 1'b0, status: dwhr_pkg::ST_POPPED,
                            last: 1'b1};
                if (op == dwhr_pkg::OP_POP_FRONT) begin
                  mem_ra  = front_q;
                  front_d = wrap_add(front_q, CW'(1));
                end else begin
                  mem_ra  = wrap_add(front_q, count_q - CW'(1));
                end
              end
            end
            dwhr_pkg::OP_SWAP: begin
              // Move the first half of the queue behind the back, one entry a cycle
              if ((count_q >> 1) != '0) begin
                cnt_d   = count_q >> 1;
                rp_d    = front_q;
                wp_d    = wrap_add(front_q, count_q);
                front_d = wrap_add(front_q, count_q >> 1);
                state_d = dwhr_pkg::FSM_SWAP;
              end
            end
            dwhr_pkg::OP_DUMP: begin
              if (count_q == '0) begin
                slot_d = '{valid: 1'b1, zero: 1'b1, status: dwhr_pkg::ST_EMPTY, last: 1'b1};
              end else begin
                cnt_d   = count_q;
                rp_d    = front_q;
                state_d = dwhr_pkg::FSM_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dwhr_pkg::FSM_SWAP: begin
        // Write back the entry read last cycle
        if (sw_pend_q) begin
          mem_we = 1'b1;
          wp_d   = wrap_add(wp_q, CW'(1));
        end
        if (cnt_q != '0) begin
          mem_re    = 1'b1;
          rp_d      = wrap_add(rp_q, CW'(1));
          cnt_d     = cnt_q - CW'(1);
          sw_pend_d = 1'b1;
        end else begin
          state_d = dwhr_pkg::FSM_IDLE;
        end
      end
      dwhr_pkg::FSM_DUMP: begin
        // Issue one read whenever the read data slot is free
        if (slot_free) begin
          mem_re = 1'b1;
          rp_d   = wrap_add(rp_q, CW'(1));
          cnt_d  = cnt_q - CW'(1);
          slot_d = '{valid: 1'b1, zero: 1'b0, status: dwhr_pkg::ST_DUMPED,
                     last: (cnt_q == CW'(1))};
          if (cnt_q == CW'(1)) begin
            state_d = dwhr_pkg::FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = dwhr_pkg::FSM_IDLE;
      end
    endcase
  end

  // Output register load
  always_comb begin
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dwhr_pkg::FSM_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      cnt_q       <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      sw_pend_q   <= 1'b0;
      slot_q      <= '{valid: 1'b0, zero: 1'b0, status: dwhr_pkg::ST_POPPED, last: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      sw_pend_q   <= sw_pend_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_value_q  <= slot_q.zero ? '0 : dwhr_pkg::ValueW'(rdata_s);
      out_status_q <= slot_q.status;
      out_last_q   <= slot_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && (mem_wa == mem_ra)))
    else $error("read and write of one entry in the same cycle");

  a_swap_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dwhr_pkg::FSM_SWAP) |-> !slot_q.valid)
    else $error("swap uses the read data register while a result waits there");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dwhr_pkg::FSM_IDLE) |-> in_stall_o)
    else $error("input taken while a swap or dump is running");

  a_swap_ends_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == dwhr_pkg::FSM_SWAP && state_q == dwhr_pkg::FSM_IDLE)
      |-> !sw_pend_q)
    else $error("swap left a write pending");

endmodule
